// ===== hdl/msct_pkg.sv =====
package msct_pkg;

   localparam int NUM_SLOTS_DEFAULT = 4;

   typedef logic [3:0]  opcode_type;
   typedef logic [1:0]  mode_type;
   typedef logic [26:0] ms_type;
   typedef logic [1:0]  div_sel_type;

   localparam opcode_type OP_TICK           = 4'd0;
   localparam opcode_type OP_SET_DURATION   = 4'd1;
   localparam opcode_type OP_START          = 4'd2;
   localparam opcode_type OP_PAUSE          = 4'd3;
   localparam opcode_type OP_RESUME         = 4'd4;
   localparam opcode_type OP_RESET          = 4'd5;
   localparam opcode_type OP_DISMISS        = 4'd6;
   localparam opcode_type OP_DISMISS_FIRST  = 4'd7;
   localparam opcode_type OP_QUERY          = 4'd8;

   localparam mode_type MODE_IDLE     = 2'd0;
   localparam mode_type MODE_RUNNING  = 2'd1;
   localparam mode_type MODE_PAUSED   = 2'd2;
   localparam mode_type MODE_FINISHED = 2'd3;

   localparam ms_type DEFAULT_MS    = 27'(30 * 60 * 1000);
   localparam ms_type ONE_SECOND_MS = 27'(1000);
   localparam ms_type CEILING_MS    = 27'(23 * 3600 * 1000 + 59 * 60 * 1000 + 59 * 1000);
   localparam ms_type ROUND_UP_MS   = 27'(999);
   localparam ms_type MIN_RESET_MS  = 27'(1000);

   localparam logic REG_MIN_DURATION = 1'b0;
   localparam logic REG_MAX_DURATION = 1'b1;

   localparam div_sel_type DIV_BY_1000 = 2'd0;
   localparam div_sel_type DIV_BY_3600 = 2'd1;
   localparam div_sel_type DIV_BY_60   = 2'd2;

   localparam int DIV_SHIFT = 37;
   localparam int DIV_Q_W   = 22;
   localparam int DIV_R_W   = 12;
   localparam int DIV_P_W   = 59;

   localparam logic [31:0] DIV_M_1000 = 32'((64'd1 << DIV_SHIFT) / 1000);
   localparam logic [31:0] DIV_M_3600 = 32'((64'd1 << DIV_SHIFT) / 3600);
   localparam logic [31:0] DIV_M_60   = 32'((64'd1 << DIV_SHIFT) / 60);

endpackage

// ===== hdl/msct_channels_if.sv =====
interface msct_req_if import msct_pkg::*; ();
   logic       valid;
   logic       ready;
   opcode_type opcode;
   logic [1:0] slot_index;
   logic [31:0] duration_value_ms;
   logic [15:0] elapsed_ms;

   modport source (output valid, output opcode, output slot_index,
                   output duration_value_ms, output elapsed_ms, input ready);
   modport sink (input valid, input opcode, input slot_index,
                 input duration_value_ms, input elapsed_ms, output ready);
endinterface

interface msct_rsp_if import msct_pkg::*; ();
   logic       valid;
   logic       ready;
   mode_type   slot_mode;
   ms_type     remaining_out_ms;
   logic [4:0] hours_left;
   logic [5:0] minutes_left;
   logic [5:0] seconds_left;
   logic       any_active;
   logic       any_finished;
   logic [1:0] first_finished;
   logic       fired;
   logic       notify;

   modport source (output valid, output slot_mode, output remaining_out_ms,
                   output hours_left, output minutes_left, output seconds_left,
                   output any_active, output any_finished, output first_finished,
                   output fired, output notify, input ready);
   modport sink (input valid, input slot_mode, input remaining_out_ms,
                 input hours_left, input minutes_left, input seconds_left,
                 input any_active, input any_finished, input first_finished,
                 input fired, input notify, output ready);
endinterface

// ===== hdl/multi_slot_countdown_timer_unit.sv =====
// Countdown timer with NUM_SLOTS independent slots.
// Requests arrive on req_if (valid/ready): a tick with the elapsed milliseconds,
// or a command or query that addresses one slot. Every request yields exactly
// one result on rsp_if with the addressed slot's mode, remaining time, its
// rounded-up h:m:s split and summary flags over all slots.
// The clamp limits for set duration are written over the csr_ APB port.
// A single reciprocal-multiply divider, one product and one correction step,
// is shared by the tick and by the h:m:s conversion.
// One request is in work at a time; the next is accepted in the cycle after
// the result has been moved to the output register.
// The output register holds a result while the receiver stalls; the block
// still accepts the next request and waits only when a second result is ready.
// Reset idles every slot, loads 30 minutes as duration and remaining time
// and restores the clamp limits to one second and 23:59:59.
module multi_slot_countdown_timer_unit import msct_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   msct_req_if.sink    req_if,
   msct_rsp_if.source  rsp_if,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_TICK     = 4'd1;
   localparam logic [3:0] ST_TICK_UPD = 4'd2;
   localparam logic [3:0] ST_CMD      = 4'd3;
   localparam logic [3:0] ST_RPT      = 4'd4;
   localparam logic [3:0] ST_HMS_HR   = 4'd5;
   localparam logic [3:0] ST_HMS_MS   = 4'd6;
   localparam logic [3:0] ST_OUT      = 4'd7;
   localparam logic [3:0] ST_WAIT1    = 4'd8;
   localparam logic [3:0] ST_WAIT2    = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [3:0] ret_ff, ret_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   opcode_type op_ff, op_in;
   logic [31:0] dur_ff, dur_in;
   logic [15:0] el_ff, el_in;
   logic fired_ff, fired_in;
   logic notify_ff, notify_in;
   logic [4:0] hours_ff, hours_in;

   mode_type mode_ff [NUM_SLOTS];
   mode_type mode_in [NUM_SLOTS];
   ms_type   dur_store_ff [NUM_SLOTS];
   ms_type   dur_store_in [NUM_SLOTS];
   ms_type   rem_store_ff [NUM_SLOTS];
   ms_type   rem_store_in [NUM_SLOTS];

   ms_type min_duration_ff, min_duration_in;
   ms_type max_duration_ff, max_duration_in;

   ms_type div_x_ff, div_x_in;
   div_sel_type div_sel_ff, div_sel_in;
   logic [DIV_P_W-1:0] prod_ff, prod_in;
   logic [DIV_Q_W-1:0] q_ff, q_in;
   logic [DIV_R_W-1:0] r_ff, r_in;

   logic rsp_valid_ff, rsp_valid_in;
   mode_type rsp_mode_ff, rsp_mode_in;
   ms_type rsp_rem_ff, rsp_rem_in;
   logic [4:0] rsp_hours_ff, rsp_hours_in;
   logic [5:0] rsp_minutes_ff, rsp_minutes_in;
   logic [5:0] rsp_seconds_ff, rsp_seconds_in;
   logic rsp_active_ff, rsp_active_in;
   logic rsp_finished_ff, rsp_finished_in;
   logic [1:0] rsp_first_ff, rsp_first_in;
   logic rsp_fired_ff, rsp_fired_in;
   logic rsp_notify_ff, rsp_notify_in;

   logic any_active;
   logic any_finished;
   logic [SLOT_W-1:0] first_idx;
   logic [SLOT_W-1:0] acc_addr;
   ms_type acc_rem;
   ms_type acc_dur;
   mode_type cur_mode;
   logic [31:0] clamp_v;
   ms_type clamped_ms;
   logic [SLOT_W-1:0] req_slot;
   logic [SLOT_W+1:0] req_slot_wide;
   logic [SLOT_W+1:0] first_wide;
   logic cfg_write;

   logic [31:0] div_m;
   ms_type div_d;
   logic [DIV_Q_W-1:0] q_est;
   ms_type qd;
   ms_type r_raw;

   // Shared divider: product stage, then estimate and one correction step.
   always_comb begin
      unique case (div_sel_ff)
         DIV_BY_3600: begin
            div_m = DIV_M_3600;
            div_d = 27'(3600);
         end
         DIV_BY_60: begin
            div_m = DIV_M_60;
            div_d = 27'(60);
         end
         default: begin
            div_m = DIV_M_1000;
            div_d = 27'(1000);
         end
      endcase
   end

   assign prod_in = DIV_P_W'(div_x_ff) * DIV_P_W'(div_m);
   assign q_est   = prod_ff[DIV_P_W-1:DIV_SHIFT];
   assign qd      = 27'(27'(q_est) * div_d);
   assign r_raw   = div_x_ff - qd;

   always_comb begin
      if (r_raw >= div_d) begin
         q_in = q_est + DIV_Q_W'(1);
         r_in = DIV_R_W'(r_raw - div_d);
      end else begin
         q_in = q_est;
         r_in = DIV_R_W'(r_raw);
      end
   end

   always_comb begin
      any_active   = 1'b0;
      any_finished = 1'b0;
      first_idx    = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (mode_ff[i] == MODE_RUNNING || mode_ff[i] == MODE_PAUSED) begin
            any_active = 1'b1;
         end
         if (mode_ff[i] == MODE_FINISHED) begin
            any_finished = 1'b1;
            first_idx    = SLOT_W'(i);
         end
      end
   end

   assign acc_addr = (state_ff == ST_CMD && op_ff == OP_DISMISS_FIRST) ? first_idx : idx_ff;
   assign acc_rem  = rem_store_ff[acc_addr];
   assign acc_dur  = dur_store_ff[acc_addr];
   assign cur_mode = mode_ff[idx_ff];

   always_comb begin
      if (dur_ff < 32'(min_duration_ff)) begin
         clamp_v = 32'(min_duration_ff);
      end else if (dur_ff > 32'(max_duration_ff)) begin
         clamp_v = 32'(max_duration_ff);
      end else begin
         clamp_v = dur_ff;
      end
      if (clamp_v > 32'(CEILING_MS)) begin
         clamped_ms = CEILING_MS;
      end else begin
         clamped_ms = clamp_v[26:0];
      end
   end

   assign req_slot_wide = (SLOT_W + 2)'(req_if.slot_index);
   assign req_slot = (32'(req_if.slot_index) < NUM_SLOTS) ? req_slot_wide[SLOT_W-1:0] : '0;
   assign first_wide = (SLOT_W + 2)'(first_idx);

   assign req_if.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      op_in        = op_ff;
      dur_in       = dur_ff;
      el_in        = el_ff;
      fired_in     = fired_ff;
      notify_in    = notify_ff;
      hours_in     = hours_ff;
      mode_in      = mode_ff;
      dur_store_in = dur_store_ff;
      rem_store_in = rem_store_ff;
      div_x_in     = div_x_ff;
      div_sel_in   = div_sel_ff;

      rsp_valid_in    = rsp_valid_ff;
      rsp_mode_in     = rsp_mode_ff;
      rsp_rem_in      = rsp_rem_ff;
      rsp_hours_in    = rsp_hours_ff;
      rsp_minutes_in  = rsp_minutes_ff;
      rsp_seconds_in  = rsp_seconds_ff;
      rsp_active_in   = rsp_active_ff;
      rsp_finished_in = rsp_finished_ff;
      rsp_first_in    = rsp_first_ff;
      rsp_fired_in    = rsp_fired_ff;
      rsp_notify_in   = rsp_notify_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               op_in     = req_if.opcode;
               slot_in   = req_slot;
               dur_in    = req_if.duration_value_ms;
               el_in     = req_if.elapsed_ms;
               fired_in  = 1'b0;
               notify_in = 1'b0;
               if (req_if.opcode == OP_TICK) begin
                  idx_in   = '0;
                  state_in = ST_TICK;
               end else begin
                  idx_in   = req_slot;
                  state_in = ST_CMD;
               end
            end
         end
         ST_TICK: begin
            if (cur_mode == MODE_RUNNING && acc_rem > 27'(el_ff)) begin
               div_x_in   = acc_rem;
               div_sel_in = DIV_BY_1000;
               ret_in     = ST_TICK_UPD;
               state_in   = ST_WAIT1;
            end else begin
               if (cur_mode == MODE_RUNNING) begin
                  mode_in[idx_ff]      = MODE_FINISHED;
                  rem_store_in[idx_ff] = '0;
                  fired_in             = 1'b1;
               end
               if (idx_ff == LAST_SLOT) begin
                  idx_in   = slot_ff;
                  state_in = ST_RPT;
               end else begin
                  idx_in   = idx_ff + SLOT_W'(1);
                  state_in = ST_TICK;
               end
            end
         end
         ST_TICK_UPD: begin
            if (el_ff > 16'(r_ff)) begin
               notify_in = 1'b1;
            end
            rem_store_in[idx_ff] = acc_rem - 27'(el_ff);
            if (idx_ff == LAST_SLOT) begin
               idx_in   = slot_ff;
               state_in = ST_RPT;
            end else begin
               idx_in   = idx_ff + SLOT_W'(1);
               state_in = ST_TICK;
            end
         end
         ST_CMD: begin
            unique case (op_ff)
               OP_SET_DURATION: begin
                  dur_store_in[acc_addr] = clamped_ms;
                  if (cur_mode == MODE_IDLE) begin
                     rem_store_in[acc_addr] = clamped_ms;
                  end
               end
               OP_START: begin
                  if (acc_rem < ONE_SECOND_MS) begin
                     rem_store_in[acc_addr] = acc_dur;
                  end
                  mode_in[acc_addr] = MODE_RUNNING;
                  notify_in         = 1'b1;
               end
               OP_PAUSE: begin
                  if (cur_mode == MODE_RUNNING) begin
                     mode_in[acc_addr] = MODE_PAUSED;
                     notify_in         = 1'b1;
                  end
               end
               OP_RESUME: begin
                  if (cur_mode == MODE_PAUSED) begin
                     if (acc_rem < ONE_SECOND_MS) begin
                        rem_store_in[acc_addr] = acc_dur;
                     end
                     mode_in[acc_addr] = MODE_RUNNING;
                     notify_in         = 1'b1;
                  end
               end
               OP_RESET: begin
                  mode_in[acc_addr]      = MODE_IDLE;
                  rem_store_in[acc_addr] = acc_dur;
                  notify_in              = 1'b1;
               end
               OP_DISMISS: begin
                  if (cur_mode == MODE_FINISHED) begin
                     mode_in[acc_addr]      = MODE_IDLE;
                     rem_store_in[acc_addr] = acc_dur;
                     notify_in              = 1'b1;
                  end
               end
               OP_DISMISS_FIRST: begin
                  if (any_finished) begin
                     mode_in[acc_addr]      = MODE_IDLE;
                     rem_store_in[acc_addr] = acc_dur;
                     notify_in              = 1'b1;
                  end
               end
               default: begin
               end
            endcase
            state_in = ST_RPT;
         end
         ST_RPT: begin
            div_x_in   = acc_rem + ROUND_UP_MS;
            div_sel_in = DIV_BY_1000;
            ret_in     = ST_HMS_HR;
            state_in   = ST_WAIT1;
         end
         ST_HMS_HR: begin
            div_x_in   = 27'(q_ff);
            div_sel_in = DIV_BY_3600;
            ret_in     = ST_HMS_MS;
            state_in   = ST_WAIT1;
         end
         ST_HMS_MS: begin
            hours_in   = q_ff[4:0];
            div_x_in   = 27'(r_ff);
            div_sel_in = DIV_BY_60;
            ret_in     = ST_OUT;
            state_in   = ST_WAIT1;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in    = 1'b1;
               rsp_mode_in     = cur_mode;
               rsp_rem_in      = acc_rem;
               rsp_hours_in    = hours_ff;
               rsp_minutes_in  = q_ff[5:0];
               rsp_seconds_in  = r_ff[5:0];
               rsp_active_in   = any_active;
               rsp_finished_in = any_finished;
               rsp_first_in    = first_wide[1:0];
               rsp_fired_in    = fired_ff;
               rsp_notify_in   = notify_ff | fired_ff;
               state_in        = ST_IDLE;
            end
         end
         ST_WAIT1: begin
            state_in = ST_WAIT2;
         end
         ST_WAIT2: begin
            state_in = ret_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign cfg_write = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      min_duration_in = min_duration_ff;
      max_duration_in = max_duration_ff;
      if (cfg_write) begin
         unique case (csr_paddr[2])
            REG_MIN_DURATION: min_duration_in = csr_pwdata[26:0];
            REG_MAX_DURATION: max_duration_in = csr_pwdata[26:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_MIN_DURATION: csr_prdata = 32'(min_duration_ff);
         REG_MAX_DURATION: csr_prdata = 32'(max_duration_ff);
         default: csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         ret_ff          <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         min_duration_ff <= MIN_RESET_MS;
         max_duration_ff <= CEILING_MS;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            mode_ff[i]      <= MODE_IDLE;
            dur_store_ff[i] <= DEFAULT_MS;
            rem_store_ff[i] <= DEFAULT_MS;
         end
      end else begin
         state_ff        <= state_in;
         ret_ff          <= ret_in;
         rsp_valid_ff    <= rsp_valid_in;
         min_duration_ff <= min_duration_in;
         max_duration_ff <= max_duration_in;
         mode_ff         <= mode_in;
         dur_store_ff    <= dur_store_in;
         rem_store_ff    <= rem_store_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      slot_ff         <= slot_in;
      op_ff           <= op_in;
      dur_ff          <= dur_in;
      el_ff           <= el_in;
      fired_ff        <= fired_in;
      notify_ff       <= notify_in;
      hours_ff        <= hours_in;
      div_x_ff        <= div_x_in;
      div_sel_ff      <= div_sel_in;
      prod_ff         <= prod_in;
      q_ff            <= q_in;
      r_ff            <= r_in;
      rsp_mode_ff     <= rsp_mode_in;
      rsp_rem_ff      <= rsp_rem_in;
      rsp_hours_ff    <= rsp_hours_in;
      rsp_minutes_ff  <= rsp_minutes_in;
      rsp_seconds_ff  <= rsp_seconds_in;
      rsp_active_ff   <= rsp_active_in;
      rsp_finished_ff <= rsp_finished_in;
      rsp_first_ff    <= rsp_first_in;
      rsp_fired_ff    <= rsp_fired_in;
      rsp_notify_ff   <= rsp_notify_in;
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.slot_mode        = rsp_mode_ff;
   assign rsp_if.remaining_out_ms = rsp_rem_ff;
   assign rsp_if.hours_left       = rsp_hours_ff;
   assign rsp_if.minutes_left     = rsp_minutes_ff;
   assign rsp_if.seconds_left     = rsp_seconds_ff;
   assign rsp_if.any_active       = rsp_active_ff;
   assign rsp_if.any_finished     = rsp_finished_ff;
   assign rsp_if.first_finished   = rsp_first_ff;
   assign rsp_if.fired            = rsp_fired_ff;
   assign rsp_if.notify           = rsp_notify_ff;

endmodule
